### src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Stream find-and-replace package
// Shared types, sizes and register codes for the find-and-replace core.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  // Pattern and replacement both hold at most eight bytes
  localparam int unsigned MaxBytes = 8;
  localparam int unsigned LenW     = 4;                 // 0 .. MaxBytes
  localparam int unsigned IdxW     = $clog2(MaxBytes);  // byte position
  localparam int unsigned WordW    = 8 * MaxBytes;

  localparam logic [LenW-1:0] LenCap = LenW'(MaxBytes);

  // Configuration register indexes
  localparam logic [1:0] RegPatternBytes     = 2'd0;
  localparam logic [1:0] RegPatternLength    = 2'd1;
  localparam logic [1:0] RegReplacementBytes = 2'd2;
  localparam logic [1:0] RegReplacementLength = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPL
  } state_t;

  // Clamp a configured length to the supported byte count
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len);
    clamp_len = (len > LenCap) ? LenCap : len;
  endfunction

endpackage

`default_nettype wire

### src/stream_find_and_replace_core.sv
// ----------------------------------------------------------------------------
// Stream find-and-replace core
// Replaces each leftmost, non-overlapping occurrence of a pattern of up to
// eight bytes in a byte stream by a replacement of zero to eight bytes.
// ----------------------------------------------------------------------------
// Sequencing: a byte is taken only in S_IDLE; S_SCAN then checks the pending
// window in the shared compare / emit unit and writes each result byte to the
// output register, and a match with a replacement goes on to S_REPL, which
// emits the replacement bytes one at a time. The next byte is taken only after
// the sequencer is back in S_IDLE, and a stalled output holds each emit step.
// Reset: rst clears the state, config registers, pending count and output valid.
`default_nettype none

module stream_find_and_replace_core
  import sfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // input stream
  input  wire logic             s_axis_tvalid,
  output      logic             s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] in_byte
  input  wire logic             s_axis_tlast,   // in_last
  // output stream
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output      logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output      logic             m_axis_tuser,   // [0] out_has_byte
  output      logic             m_axis_tlast,   // out_last
  // configuration write port
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [WordW-1:0] cfg_data
);

  // configuration registers
  logic [WordW-1:0] pattern_bytes;
  logic [LenW-1:0]  pattern_length;
  logic [WordW-1:0] replacement_bytes;
  logic [LenW-1:0]  replacement_length;

  // pending window, oldest byte at position 0
  logic [7:0]      win [MaxBytes];
  logic [LenW-1:0] cnt;
  logic            last_q;
  logic [IdxW-1:0] ridx;

  state_t state, state_next;

  logic [LenW-1:0] plen, rlen;
  logic [LenW-1:0] wr_pos;
  logic            s_fire;
  logic            out_free;
  logic            prefix_eq;
  logic            pass_mode;
  logic            full_match;
  logic            partial_match;
  logic            rep_end;

  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_has;
  logic            emit_last;
  logic            step;

  assign plen     = clamp_len(pattern_length);
  assign rlen     = clamp_len(replacement_length);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign wr_pos   = (cnt >= plen) ? '0 : cnt;
  assign rep_end  = ({1'b0, ridx} == (rlen - LenW'(1)));

  // shared compare unit: pending window against the pattern head
  always_comb begin
    prefix_eq = 1'b1;
    for (int i = 0; i < MaxBytes; i++) begin
      if ((LenW'(i) < cnt) && (win[i] != pattern_bytes[8*i +: 8])) begin
        prefix_eq = 1'b0;
      end
    end
  end

  assign pass_mode     = (plen == '0);
  assign full_match    = !pass_mode && (cnt == plen) && prefix_eq;
  assign partial_match = !pass_mode && (cnt < plen) && prefix_eq;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt == '0) begin
          state_next = S_IDLE;
        end else if (full_match) begin
          if (rlen != '0) begin
            state_next = S_REPL;
          end else if (!last_q || out_free) begin
            state_next = S_IDLE;
          end
        end else if (partial_match && !last_q) begin
          state_next = S_IDLE;
        end else if (out_free && (cnt == LenW'(1))) begin
          state_next = S_IDLE;
        end
      end
      S_REPL: begin
        if (out_free && rep_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    emit_byte     = '0;
    emit_has      = 1'b1;
    emit_last     = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_SCAN: begin
        if (cnt == '0) begin
          emit = 1'b0;
        end else if (full_match) begin
          // empty replacement on the final byte leaves a bare end marker
          if ((rlen == '0) && last_q) begin
            emit      = 1'b1;
            emit_has  = 1'b0;
            emit_last = 1'b1;
          end
        end else if (partial_match && !last_q) begin
          emit = 1'b0;
        end else begin
          // mismatch, or flush at end of text: drop the oldest byte out
          emit      = 1'b1;
          emit_byte = win[0];
          emit_last = last_q && (cnt == LenW'(1));
        end
      end
      S_REPL: begin
        emit      = 1'b1;
        emit_byte = replacement_bytes[8*ridx +: 8];
        emit_last = last_q && rep_end;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign step = !emit || out_free;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      cnt                <= '0;
      ridx               <= '0;
      last_q             <= 1'b0;
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          RegPatternBytes: begin
            pattern_bytes <= cfg_data;
            cnt           <= '0;
          end
          RegPatternLength: begin
            pattern_length <= cfg_data[LenW-1:0];
            cnt            <= '0;
          end
          RegReplacementBytes:  replacement_bytes  <= cfg_data;
          RegReplacementLength: replacement_length <= cfg_data[LenW-1:0];
          default: ;
        endcase
      end else if (s_fire) begin
        cnt    <= wr_pos + LenW'(1);
        last_q <= s_axis_tlast;
      end else if ((state == S_SCAN) && step && (cnt != '0)) begin
        if (full_match) begin
          cnt  <= '0;
          ridx <= '0;
        end else if (emit) begin
          cnt <= cnt - LenW'(1);
        end
      end else if ((state == S_REPL) && out_free) begin
        ridx <= ridx + IdxW'(1);
      end

      if (emit && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // window storage and output register payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      win[wr_pos[IdxW-1:0]] <= s_axis_tdata;
    end else if ((state == S_SCAN) && emit && emit_has && out_free) begin
      for (int i = 0; i < MaxBytes - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
    if (emit && out_free) begin
      m_axis_tdata <= emit_byte;
      m_axis_tuser <= emit_has;
      m_axis_tlast <= emit_last;
    end
  end

  // pending window never holds more than the longest pattern
  assert property (@(posedge clk) disable iff (rst) cnt <= LenCap)
    else $error("pending count above window depth");

  // between bytes the window holds only a proper prefix
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((cnt == '0) || (cnt < plen)))
    else $error("idle with a full or stale window");

  // a bare end marker always closes the text
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("bare marker without last");

  // a taken byte always goes to the compare step next
  assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (state == S_SCAN))
    else $error("input transfer not followed by scan");

  // replacement runs only after the window was consumed by a match
  assert property (@(posedge clk) disable iff (rst)
    (state == S_REPL) |-> (cnt == '0))
    else $error("replacement with bytes pending");

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Stream find-and-replace core testbench
// Streams short texts through the core under random valid/ready gaps and
// checks every output transfer against a cycle-free rewrite predictor.
// Directed texts cover pass-through, recheck after mismatch, saturated
// lengths, deletion, bare end markers and a pattern change mid-text; random
// phases then build texts from pattern fragments under varied settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import sfr_pkg::*;
();

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } out_byte_t;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseItems  = 8;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic             s_axis_tlast = 1'b0;    // in_last
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;           // [7:0] out_byte
  logic             m_axis_tuser;           // [0] out_has_byte
  logic             m_axis_tlast;           // out_last
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = RegPatternBytes;
  logic [WordW-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  stream_find_and_replace_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Predictor copy of the registers and the held pattern prefix
  logic [WordW-1:0]   pat_word = '0;
  logic [WordW-1:0]   rep_word = '0;
  logic [LenW-1:0]    pat_len  = '0;
  logic [LenW-1:0]    rep_len  = '0;
  logic [WordW-1:0]   held_word = '0;
  int unsigned        held_count = 0;

  text_byte_t         pending_text[$];
  out_byte_t          expected_text[$];
  out_byte_t          head_result;
  logic [7:0]         text_buf[$];
  logic [23:0]        alphabet = 24'h636261;

  int unsigned        fail_count = 0;
  int unsigned        send_idle_pct = 23;
  int unsigned        recv_idle_pct = 56;
  int unsigned        quiet_cycles = 0;

  // Rewrite one accepted byte and queue the output it must produce
  task automatic rewrite_byte(input logic [7:0] b, input logic is_last);
    out_byte_t                 outs[$];
    logic [16*8-1:0]           win;
    int unsigned               plen, rlen, p, m, start, len, i;
    bit                        prefix, stop;
    plen = (pat_len > LenCap) ? LenCap : pat_len;
    rlen = (rep_len > LenCap) ? LenCap : rep_len;
    win = '0;
    if (plen == 0) begin
      held_count = 0;
      outs.insert(outs.size(), {b, 1'b1, 1'b0});
    end else begin
      p = (held_count >= plen) ? 0 : held_count;
      win[WordW-1:0] = held_word;
      win[8*p +: 8] = b;
      m = p + 1;
      start = 0;
      stop = 0;
      while (start < m && !stop) begin
        len = m - start;
        prefix = 1;
        for (i = 0; i < len; i++)
          if (win[8*(start+i) +: 8] != pat_word[8*i +: 8]) prefix = 0;
        if (prefix && len == plen) begin
          for (i = 0; i < rlen; i++)
            outs.insert(outs.size(), {rep_word[8*i +: 8], 1'b1, 1'b0});
          start = m;
        end else if (prefix) begin
          stop = 1;
        end else begin
          // emit the oldest held byte and recheck the shorter suffix
          outs.insert(outs.size(), {win[8*start +: 8], 1'b1, 1'b0});
          start++;
        end
      end
      held_count = m - start;
      held_word = win[8*start +: WordW];
    end
    if (is_last) begin
      for (i = 0; i < held_count; i++)
        outs.insert(outs.size(), {held_word[8*i +: 8], 1'b1, 1'b0});
      held_count = 0;
      if (outs.size() == 0) outs.insert(0, {8'h00, 1'b0, 1'b0});
      outs[outs.size()-1].last = 1'b1;
    end
    foreach (outs[j]) expected_text.insert(expected_text.size(), outs[j]);
  endtask

  // Input side: hold a byte until its transfer, then load the next one
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) rewrite_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_text.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_text[0].data;
          s_axis_tlast  <= pending_text[0].last;
          void'(pending_text.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each transfer against the oldest expected byte
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected output data=%02h has_byte=%0b last=%0b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count++;
        end else begin
          head_result = expected_text.pop_front();
          if ({m_axis_tdata, m_axis_tuser, m_axis_tlast} !== head_result) begin
            $display("%0t: mismatch expected data=%02h has_byte=%0b last=%0b,",
                     $time, head_result.data, head_result.has_byte, head_result.last,
                     " got data=%02h has_byte=%0b last=%0b",
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one register write; call at a rising edge, returns at the edge it lands
  task automatic write_reg(input logic [1:0] idx, input logic [WordW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      RegPatternBytes: begin
        pat_word = val;
        held_count = 0;
      end
      RegPatternLength: begin
        pat_len = val[LenW-1:0];
        held_count = 0;
      end
      RegReplacementBytes:  rep_word = val;
      RegReplacementLength: rep_len = val[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input bit with_pattern,
                            input logic [WordW-1:0] pw, input logic [WordW-1:0] pl,
                            input logic [WordW-1:0] rw, input logic [WordW-1:0] rl);
    if (with_pattern) begin
      write_reg(RegPatternBytes, pw);
      write_reg(RegPatternLength, pl);
    end
    write_reg(RegReplacementBytes, rw);
    write_reg(RegReplacementLength, rl);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(input logic [7:0] b, input logic is_last);
    pending_text.insert(pending_text.size(), {b, is_last});
  endtask

  // Wait until every byte is through, then let the core settle
  task automatic drain();
    while (pending_text.size() != 0 || s_axis_tvalid || expected_text.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Build texts from pattern pieces and the phase alphabet
  task automatic fill_phase_text(input int unsigned n_items);
    int unsigned count, target, plen, r, cut, i;
    bit          open_end;
    count = 0;
    plen = (pat_len > LenCap) ? LenCap : pat_len;
    while (count < n_items) begin
      text_buf.delete();
      target = $urandom_range(1, 10);
      while (text_buf.size() < target) begin
        r = $urandom_range(99);
        if (r < 30 && plen > 0) begin
          for (i = 0; i < plen; i++) text_buf.insert(text_buf.size(), pat_word[8*i +: 8]);
        end else if (r < 50 && plen > 1) begin
          cut = $urandom_range(1, plen - 1);
          for (i = 0; i < cut; i++) text_buf.insert(text_buf.size(), pat_word[8*i +: 8]);
        end else if (r < 85) begin
          text_buf.insert(text_buf.size(), alphabet[8*$urandom_range(2) +: 8]);
        end else begin
          text_buf.insert(text_buf.size(), 8'($urandom_range(255)));
        end
      end
      // leave the final text of a phase open now and then
      open_end = (count + text_buf.size() >= n_items) && ($urandom_range(99) < 25);
      foreach (text_buf[j]) push_item(text_buf[j], !open_end && j == text_buf.size() - 1);
      count += text_buf.size();
    end
  endtask

  initial begin
    logic [WordW-1:0] pw, pl, rw, rl;
    bit               with_pattern;
    int unsigned      r, i;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // pass-through with the reset settings
    set_config(1, '0, '0, '0, '0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    drain();

    // "aab" in "aaabc": mismatch on the third byte rechecks the suffix
    set_config(1, 64'h626161, 64'd3, 64'h5A, 64'd1);
    push_item(8'h61, 1'b0);
    push_item(8'h61, 1'b0);
    push_item(8'h61, 1'b0);
    push_item(8'h62, 1'b0);
    push_item(8'h63, 1'b1);
    drain();

    // oversized lengths saturate to eight bytes
    set_config(1, {WordW{1'b1}}, 64'hF, 64'h8877665544332211, 64'hF);
    for (i = 0; i < 8; i++) push_item(8'hFF, i == 7);
    drain();

    // empty replacement: match on the final byte leaves a bare end marker
    set_config(1, 64'h71, 64'd1, 64'h0, 64'd0);
    push_item(8'h71, 1'b1);
    push_item(8'h78, 1'b0);
    push_item(8'h71, 1'b1);
    drain();

    // pattern write mid-text drops the held prefix; a final byte flushes a held prefix
    set_config(1, 64'h636261, 64'd3, 64'h2D, 64'd1);
    push_item(8'h61, 1'b0);
    push_item(8'h62, 1'b0);
    drain();
    write_reg(RegPatternLength, 64'd3);
    cfg_we <= 1'b0;
    push_item(8'h63, 1'b1);
    push_item(8'h61, 1'b0);
    push_item(8'h62, 1'b1);
    drain();

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      if (ph == RandPhases / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 23;
      end else if (ph == 2 * RandPhases / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      with_pattern = (ph == 0) || ($urandom_range(99) < 75);
      if (with_pattern)
        alphabet = {8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255))};
      for (i = 0; i < 8; i++)
        pw[8*i +: 8] = ($urandom_range(99) < 80) ? alphabet[8*$urandom_range(2) +: 8]
                                                 : 8'($urandom_range(255));
      r = $urandom_range(99);
      pl = 64'((r < 8) ? 0 : (r < 16) ? $urandom_range(9, 15) :
               (r < 26) ? 8 : $urandom_range(1, 4));
      rw = {$urandom, $urandom};
      r = $urandom_range(99);
      rl = 64'((r < 15) ? 0 : (r < 25) ? $urandom_range(9, 15) : $urandom_range(0, 8));
      // upper data bits are ignored by the length registers
      if ($urandom_range(1)) begin
        pl = {$urandom, $urandom} & ~64'hF | pl;
        rl = {$urandom, $urandom} & ~64'hF | rl;
      end
      set_config(with_pattern, pw, pl, rw, rl);
      fill_phase_text(PhaseItems);
      drain();
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
